FILE: rtl/core/hd_pkg.sv
// ----------------------------------------------------------------------------
// hd_pkg
// Shared types and constants for the hyperboloid distance block.
// ----------------------------------------------------------------------------
package hd_pkg;

  localparam int unsigned AccW  = 40;
  localparam int unsigned CoordW = 16;
  localparam int unsigned DistW = 24;
  localparam int unsigned CurvW = 16;

  localparam logic [AccW-1:0] OneQ24 = 40'd16777216;
  localparam logic [31:0]     Ln2Q32 = 32'd2977044472;
  localparam logic [15:0]     CurvReset = 16'd4096;

  localparam logic RegCurv = 1'b0;

  typedef struct packed {
    logic [AccW-1:0]        norm_a;
    logic [AccW-1:0]        norm_b;
    logic signed [AccW-1:0] dot;
  } pair_t;

endpackage

FILE: rtl/core/hyperboloid_distance_top.sv
// Throughput: one coordinate request per cycle while busy is low; the back end
//   takes the next pair only when idle, after the shared 40-step square root
//   (run twice) and 24-step log2 loop of the previous distance.
// A two-entry pair queue decouples accumulation from the back end.
// Reset (rst_ni low, async) reinitialises accumulators and clears queue and sequencer.
// done_o pulses one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// hyperboloid_distance_top
// Hyperbolic distance between two streamed vectors, Q8.16 result.
// ----------------------------------------------------------------------------
module hyperboloid_distance_top #(
  parameter int unsigned DIMENSIONS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] coord_first_i,
  input  logic signed [15:0] coord_second_i,
  input  logic               last_coord_i,
  output logic               done_o,
  output logic [23:0]        distance_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hd_pkg::*;

  logic        accept;
  logic        push, pop;
  pair_t       pair_in, pair_head;
  logic [1:0]  q_count;
  logic [15:0] curv_q;

  assign busy = (q_count == 2'd2);
  assign accept = start && !busy;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curv_q <= CurvReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegCurv)) begin
      curv_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == RegCurv) ? {16'd0, curv_q} : 32'd0;

  hd_front #(.DIMENSIONS(DIMENSIONS)) u_front (
    .clk_i, .rst_ni,
    .accept_i(accept),
    .coord_first_i, .coord_second_i, .last_coord_i,
    .push_o(push),
    .pair_o(pair_in)
  );

  hd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .pair_i(pair_in),
    .pop_i(pop), .pair_o(pair_head),
    .count_o(q_count)
  );

  hd_back u_back (
    .clk_i, .rst_ni,
    .avail_i(q_count != 2'd0),
    .pair_i(pair_head),
    .curv_i(curv_q),
    .pop_o(pop),
    .done_o, .distance_o
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !push) else $error("push into full queue");
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back results");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_count != 2'd0)) else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/hd_front.sv
// ----------------------------------------------------------------------------
// hd_front
// Accumulates norms and dot product, hands finished pairs downstream.
// ----------------------------------------------------------------------------
module hd_front #(
  parameter int unsigned DIMENSIONS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic signed [15:0]   coord_first_i,
  input  logic signed [15:0]   coord_second_i,
  input  logic                 last_coord_i,
  output logic                 push_o,
  output hd_pkg::pair_t        pair_o
);
  import hd_pkg::*;

  localparam int unsigned CntW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(DIMENSIONS - 1);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [AccW-1:0]        na_q, na_d, nb_q, nb_d;
  logic signed [AccW-1:0] cr_q, cr_d;
  logic signed [31:0]     paa, pbb, pab;
  logic [AccW-1:0]        na_sum, nb_sum;
  logic signed [AccW-1:0] cr_sum;
  logic                   pair_end;

  always_comb begin
    paa = coord_first_i * coord_first_i;
    pbb = coord_second_i * coord_second_i;
    pab = coord_first_i * coord_second_i;
    na_sum = na_q + {{(AccW-32){1'b0}}, paa};
    nb_sum = nb_q + {{(AccW-32){1'b0}}, pbb};
    cr_sum = cr_q + {{(AccW-32){pab[31]}}, pab};
    pair_end = last_coord_i || (cnt_q == CntLast);
    push_o = accept_i && pair_end;
    pair_o = '{norm_a: na_sum, norm_b: nb_sum, dot: cr_sum};
    cnt_d = cnt_q;
    na_d = na_q;
    nb_d = nb_q;
    cr_d = cr_q;
    if (accept_i) begin
      if (pair_end) begin
        cnt_d = '0;
        na_d = OneQ24;
        nb_d = OneQ24;
        cr_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        na_d = na_sum;
        nb_d = nb_sum;
        cr_d = cr_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      na_q <= OneQ24;
      nb_q <= OneQ24;
      cr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      na_q <= na_d;
      nb_q <= nb_d;
      cr_q <= cr_d;
    end
  end

endmodule

FILE: rtl/core/hd_queue.sv
// ----------------------------------------------------------------------------
// hd_queue
// Two-entry queue of finished pairs between front and back.
// ----------------------------------------------------------------------------
module hd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hd_pkg::pair_t pair_i,
  input  logic          pop_i,
  output hd_pkg::pair_t pair_o,
  output logic [1:0]    count_o
);
  import hd_pkg::*;

  pair_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign pair_o = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

FILE: rtl/core/hd_back.sv
// ----------------------------------------------------------------------------
// hd_back
// Sequential datapath: two multiply/square-root passes, log2, scaling.
// ----------------------------------------------------------------------------
module hd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  hd_pkg::pair_t pair_i,
  input  logic [15:0]   curv_i,
  output logic          pop_o,
  output logic          done_o,
  output logic [23:0]   distance_o
);
  import hd_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMul   = 4'd1;
  localparam logic [3:0] StSqrt  = 4'd2;
  localparam logic [3:0] StTcalc = 4'd3;
  localparam logic [3:0] StNorm  = 4'd4;
  localparam logic [3:0] StLog   = 4'd5;
  localparam logic [3:0] StLn    = 4'd6;
  localparam logic [3:0] StScale = 4'd7;

  logic [3:0]             st_q;
  logic                   phase_q;
  logic [5:0]             it_q;
  logic [39:0]            op_a_q;
  logic [47:0]            op_b_q;
  logic [79:0]            prod_q;
  logic [43:0]            rem_q;
  logic [39:0]            root_q;
  logic signed [39:0]     cross_q;
  logic [39:0]            t_q;
  logic [39:0]            x_q;
  logic [5:0]             e_q;
  logic [30:0]            m_q;
  logic [23:0]            frac_q;
  logic [27:0]            ln_q;
  logic                   done_q;
  logic [23:0]            dist_q;

  logic [55:0]            pp;
  logic [43:0]            rem_sh;
  logic [43:0]            trial;
  logic signed [41:0]     t_s;
  logic [61:0]            sq;
  logic [31:0]            mm;
  logic [59:0]            lnp;
  logic [27:0]            log2v;
  logic [43:0]            scl;
  logic [5:0]             e_off;

  always_comb begin
    pp = op_a_q * op_b_q[47:32];
    rem_sh = {rem_q[41:0], prod_q[79:78]};
    trial = {2'b00, root_q, 2'b01};
    t_s = $signed({2'b00, root_q}) - {{2{cross_q[39]}}, cross_q};
    sq = m_q * m_q;
    mm = sq[61:30];
    e_off = e_q - 6'd24;
    log2v = {e_off[3:0], frac_q};
    lnp = log2v * Ln2Q32;
    scl = ln_q * curv_i;
  end

  assign pop_o = (st_q == StIdle) && avail_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      done_q <= 1'b0;
      phase_q <= 1'b0;
      it_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (avail_i) begin
            phase_q <= 1'b0;
            it_q <= 6'd2;
            st_q <= StMul;
          end
        end
        StMul: begin
          if (it_q == 6'd0) begin
            it_q <= 6'd39;
            st_q <= StSqrt;
          end else begin
            it_q <= it_q - 6'd1;
          end
        end
        StSqrt: begin
          if (it_q == 6'd0) begin
            st_q <= phase_q ? StNorm : StTcalc;
          end else begin
            it_q <= it_q - 6'd1;
          end
        end
        StTcalc: begin
          phase_q <= 1'b1;
          it_q <= 6'd2;
          st_q <= StMul;
        end
        StNorm: begin
          if (x_q[39]) begin
            it_q <= 6'd23;
            st_q <= StLog;
          end
        end
        StLog: begin
          if (it_q == 6'd0) begin
            st_q <= StLn;
          end else begin
            it_q <= it_q - 6'd1;
          end
        end
        StLn: st_q <= StScale;
        StScale: begin
          done_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        op_a_q <= pair_i.norm_a;
        op_b_q <= {8'd0, pair_i.norm_b};
        cross_q <= pair_i.dot;
        prod_q <= '0;
      end
      StMul: begin
        prod_q <= {prod_q[63:0], 16'd0} + {24'd0, pp};
        op_b_q <= {op_b_q[31:0], 16'd0};
        rem_q <= '0;
        root_q <= '0;
      end
      StSqrt: begin
        prod_q <= {prod_q[77:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q <= rem_sh - trial;
          root_q <= {root_q[38:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          root_q <= {root_q[38:0], 1'b0};
        end
        x_q <= t_q + {root_q[38:0], (rem_sh >= trial)};
        e_q <= 6'd39;
      end
      StTcalc: begin
        if (t_s < $signed({2'b00, OneQ24})) begin
          t_q <= OneQ24;
          op_a_q <= '0;
          op_b_q <= {8'd0, OneQ24 + OneQ24};
        end else begin
          t_q <= t_s[39:0];
          op_a_q <= t_s[39:0] - OneQ24;
          op_b_q <= {8'd0, t_s[39:0] + OneQ24};
        end
        prod_q <= '0;
      end
      StNorm: begin
        if (!x_q[39]) begin
          x_q <= {x_q[38:0], 1'b0};
          e_q <= e_q - 6'd1;
        end
        m_q <= x_q[39:9];
        frac_q <= '0;
      end
      StLog: begin
        if (mm[31]) begin
          m_q <= mm[31:1];
          frac_q <= {frac_q[22:0], 1'b1};
        end else begin
          m_q <= mm[30:0];
          frac_q <= {frac_q[22:0], 1'b0};
        end
      end
      StLn: ln_q <= lnp[59:32];
      StScale: dist_q <= scl[43:20];
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign distance_o = dist_q;

endmodule
